### hdl/ipv6_literal_validator_unit_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef IPV6_LITERAL_VALIDATOR_UNIT_MACROS_SVH
`define IPV6_LITERAL_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPV6LV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ipv6lv assertion failed");

// Next-cycle implication, checked outside reset.
`define IPV6LV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ipv6lv assertion failed");

`endif

### hdl/ipv6lv_pkg.sv
package ipv6lv_pkg;

   localparam logic [7:0] CHAR_PERCENT  = 8'h25;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_TWO      = 8'h32;
   localparam logic [7:0] CHAR_FIVE     = 8'h35;

   localparam logic [2:0] GROUP_MAX           = 3'd4;
   localparam logic [2:0] GLEN_SAT            = 3'd5;
   localparam logic [3:0] CGRP_SAT            = 4'd15;
   localparam logic [3:0] COLONS_FULL         = 4'd7;
   localparam logic [3:0] COLONS_DOUBLE_LIMIT = 4'd6;
   localparam logic [1:0] ZPOS_SAT            = 2'd3;
   localparam logic [1:0] ZPOS_BR_MIN         = 2'd3;
   localparam logic [1:0] ZPOS_PLAIN_MIN      = 2'd1;

   typedef enum logic [1:0] {
      PH_START,
      PH_ADDR,
      PH_ZONE
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       mode;
      logic [2:0] glen;
      logic [3:0] cgrp;
      logic       dseen;
      logic [1:0] zpos;
      logic       failed;
   } scan_state_type;

   localparam scan_state_type SCAN_CLEAR = '{
      phase:  PH_START,
      mode:   1'b0,
      glen:   3'd0,
      cgrp:   4'd0,
      dseen:  1'b0,
      zpos:   2'd0,
      failed: 1'b0
   };

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
      logic       bracketed;
   } req_item_type;

   typedef struct packed {
      logic emit;
      logic is_valid;
   } verdict_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h41 && c <= 8'h5A);
   endfunction

endpackage

### hdl/ipv6lv_if.sv
interface ipv6lv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       last_byte;
   logic       bracketed;

   modport source (output valid, output char_byte, output last_byte, output bracketed,
                   input ready);
   modport sink (input valid, input char_byte, input last_byte, input bracketed,
                 output ready);
endinterface

interface ipv6lv_rsp_if;
   logic valid;
   logic ready;
   logic is_valid;

   modport source (output valid, output is_valid, input ready);
   modport sink (input valid, input is_valid, output ready);
endinterface

### hdl/ipv6lv_scan.sv
module ipv6lv_scan import ipv6lv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   output verdict_type  verdict
);

   scan_state_type state_ff;
   scan_state_type state_in;
   scan_state_type cur;

   // One address or zone byte.
   function automatic scan_state_type take_content(input scan_state_type s,
                                                   input logic [7:0] c);
      scan_state_type r;
      r = s;
      if (s.phase == PH_ZONE) begin
         case (s.zpos)
            2'd0: begin
               if (s.mode ? (c != CHAR_TWO) : !is_alnum(c)) r.failed = 1'b1;
            end
            2'd1: begin
               if (s.mode && c != CHAR_FIVE) r.failed = 1'b1;
            end
            2'd2: begin
               if (s.mode && !is_alnum(c)) r.failed = 1'b1;
            end
            default: begin
            end
         endcase
         if (s.zpos < ZPOS_SAT) r.zpos = s.zpos + 2'd1;
      end else if (c == CHAR_PERCENT) begin
         if (s.glen == 3'd0) r.failed = 1'b1;
         r.phase = PH_ZONE;
         r.zpos  = 2'd0;
      end else if (c == CHAR_COLON) begin
         if (s.glen == 3'd0) begin
            if (s.dseen) r.failed = 1'b1;
            r.dseen = 1'b1;
         end else if (s.cgrp < CGRP_SAT) begin
            r.cgrp = s.cgrp + 4'd1;
         end
         r.glen = 3'd0;
      end else if (is_hex(c)) begin
         if (s.glen < GLEN_SAT) r.glen = s.glen + 3'd1;
         if (r.glen > GROUP_MAX) r.failed = 1'b1;
      end else begin
         r.failed = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      cur = state_ff;
      if (state_ff.phase == PH_START) begin
         cur       = SCAN_CLEAR;
         cur.mode  = item.bracketed;
         cur.phase = PH_ADDR;
      end
      state_in = cur;
      verdict  = '0;
      if (state_ff.phase == PH_START && item.bracketed) begin
         // opening bracket only; a lone byte is rejected outright
         if (item.char_byte != CHAR_LBRACKET || item.last_byte) state_in.failed = 1'b1;
         if (item.last_byte) begin
            verdict.emit     = 1'b1;
            verdict.is_valid = 1'b0;
            state_in         = SCAN_CLEAR;
         end
      end else if (!item.last_byte) begin
         state_in = take_content(cur, item.char_byte);
      end else begin
         if (cur.mode) begin
            if (item.char_byte != CHAR_RBRACKET) state_in.failed = 1'b1;
         end else begin
            state_in = take_content(cur, item.char_byte);
         end
         if (state_in.phase == PH_ZONE) begin
            if (state_in.zpos < (state_in.mode ? ZPOS_BR_MIN : ZPOS_PLAIN_MIN))
               state_in.failed = 1'b1;
         end else if (state_in.glen == 3'd0 || state_in.glen > GROUP_MAX) begin
            state_in.failed = 1'b1;
         end
         verdict.emit     = 1'b1;
         verdict.is_valid = !state_in.failed &&
                            (state_in.dseen ? (state_in.cgrp < COLONS_DOUBLE_LIMIT)
                                            : (state_in.cgrp == COLONS_FULL));
         state_in = SCAN_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_CLEAR;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/ipv6_literal_validator_unit.sv
// IPv6 literal checker for a byte stream: one string byte per req item, with
// last_byte marking the end and bracketed (taken from the first byte) selecting
// the "[addr%25zone]" form. One verdict item (is_valid) comes out per string,
// on rsp, from the result register once its last byte leaves the input register.
// The block takes one byte every cycle unless a stalled rsp holds it; the per-byte
// scan state is updated by logic between the input register and the result
// register, and the input register keeps accepting while a verdict waits in the
// result register unless the waiting byte would itself emit one.
`include "ipv6_literal_validator_unit_macros.svh"

module ipv6_literal_validator_unit import ipv6lv_pkg::*; (
   input logic             clock,
   input logic             reset,
   ipv6lv_req_if.sink      req_if,
   ipv6lv_rsp_if.source    rsp_if
);

   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   logic         out_bit_ff;
   logic         advance;
   logic         req_take;
   verdict_type  verdict;

   ipv6lv_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (in_item_ff),
      .verdict (verdict)
   );

   // a byte that emits needs room in the result register
   assign advance = in_valid_ff &&
                    (!verdict.emit || !out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && verdict.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.char_byte <= req_if.char_byte;
         in_item_ff.last_byte <= req_if.last_byte;
         in_item_ff.bracketed <= req_if.bracketed;
      end
      if (advance && verdict.emit) begin
         out_bit_ff <= verdict.is_valid;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.is_valid = out_bit_ff;

   `IPV6LV_ASSERT_NOW(a_no_overwrite, out_valid_ff && !rsp_if.ready, !(advance && verdict.emit))
   `IPV6LV_ASSERT_NEXT(a_emit_lands, advance && verdict.emit, out_valid_ff)
   `IPV6LV_ASSERT_NEXT(a_hold_byte, in_valid_ff && !advance, in_valid_ff)
   `IPV6LV_ASSERT_NOW(a_emit_on_last, advance && in_item_ff.last_byte, verdict.emit)

endmodule

### dv/ipv6_literal_validator_unit_tb.sv
module ipv6_literal_validator_unit_tb;
   import ipv6lv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int    RANDOM_BYTES  = 1950;
   localparam int    CYCLE_LIMIT   = 200000;
   localparam int    SHOW_LIMIT    = 10;
   localparam int    IDLE_PCT      = 9;
   localparam int    NO_VERDICT    = -1;
   localparam string HEX_CHARS     = "0123456789abcdefABCDEF";
   localparam string ALNUM_CHARS   =
      "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   localparam string SPECIAL_CHARS = ":%[]25aZg. ";

   typedef struct {
      string text;
      bit    br;
      int    verdict;   // NO_VERDICT: taken from the scanner model
   } lit_case_type;

   lit_case_type lit_cases[25] = '{
      '{"::1",                                  1'b0, 0},
      '{"1:2:3:4:5:6:7:8",                      1'b0, 1},
      '{"ffff:FFFF:0:0:0:0:0:abcd",             1'b0, 1},
      '{"1::",                                  1'b0, 0},
      '{"1::8",                                 1'b0, NO_VERDICT},
      '{"12345::1",                             1'b0, 0},
      '{"[fe80::1%25eth0]",                     1'b1, 1},
      '{"[fe80::1%eth0]",                       1'b1, 0},
      '{"fe80::1%eth0",                         1'b0, 1},
      '{"fe80::1%",                             1'b0, 0},
      '{"[fe80::1%25]",                         1'b1, 0},
      '{"[",                                    1'b1, 0},
      '{"[1::2",                                1'b1, 0},
      '{"1:2:3:4:5:6:7:8:9",                    1'b0, 0},
      '{"1:2:3:4:5:6::7",                       1'b0, NO_VERDICT},
      '{"1:2:3:4:5::6",                         1'b0, NO_VERDICT},
      '{"1:2:3:4:5:6:7:8:9:a:b:c:d:e:f:1:2:3",  1'b0, 0},
      '{"g::1",                                 1'b0, 0},
      '{"1:2:3:4:5:6:7:8%a%:]",                 1'b0, 1},
      '{"[1:2:3:4:5:6:7:8%25z%]]",              1'b1, NO_VERDICT},
      '{"%a",                                   1'b0, 0},
      '{":1",                                   1'b0, NO_VERDICT},
      '{"1",                                    1'b0, 0},
      '{"x",                                    1'b1, 0},
      '{"a:b:c:d:e:f:0:1",                      1'b1, 0}
   };

   logic clock;
   logic reset;

   ipv6lv_req_if req_if();
   ipv6lv_rsp_if rsp_if();

   ipv6_literal_validator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // scanner model state
   phase_type  scan_phase;
   bit         scan_br;
   logic [2:0] scan_glen;
   logic [3:0] scan_colons;
   bit         scan_double;
   logic [1:0] scan_zpos;
   bit         scan_bad;

   bit         verdicts_due[$];
   logic [7:0] str_bytes[$];
   bit         str_br;
   int         row_verdict = NO_VERDICT;
   bit         calm;
   int         bytes_sent;
   int         strings_sent;
   int         errors;
   int         cycles;
   int         seen_valid;
   int         seen_invalid;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit hex_digit(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic bit alnum_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   task scan_clear();
      scan_phase  = PH_START;
      scan_br     = 1'b0;
      scan_glen   = '0;
      scan_colons = '0;
      scan_double = 1'b0;
      scan_zpos   = '0;
      scan_bad    = 1'b0;
   endtask

   // one address or zone byte
   task scan_content(input logic [7:0] c);
      if (scan_phase == PH_ZONE) begin
         case (scan_zpos)
            2'd0: if (scan_br ? (c != CHAR_TWO) : !alnum_char(c)) scan_bad = 1'b1;
            2'd1: if (scan_br && c != CHAR_FIVE) scan_bad = 1'b1;
            2'd2: if (scan_br && !alnum_char(c)) scan_bad = 1'b1;
            default: ;
         endcase
         if (scan_zpos != ZPOS_SAT) scan_zpos++;
      end else if (c == CHAR_PERCENT) begin
         if (scan_glen == 0) scan_bad = 1'b1;
         scan_phase = PH_ZONE;
         scan_zpos  = '0;
      end else if (c == CHAR_COLON) begin
         if (scan_glen == 0) begin
            if (scan_double) scan_bad = 1'b1;
            scan_double = 1'b1;
         end else if (scan_colons != CGRP_SAT) begin
            scan_colons++;
         end
         scan_glen = '0;
      end else if (hex_digit(c)) begin
         if (scan_glen < GLEN_SAT) scan_glen++;
         if (scan_glen > GROUP_MAX) scan_bad = 1'b1;
      end else begin
         scan_bad = 1'b1;
      end
   endtask

   task scan_byte(input logic [7:0] c, input bit last, input bit br,
                  output bit emit, output bit verdict);
      emit    = 1'b0;
      verdict = 1'b0;
      if (scan_phase == PH_START) begin
         scan_clear();
         scan_br    = br;
         scan_phase = PH_ADDR;
         if (scan_br) begin
            // opening bracket is not content; a lone byte can never close
            if (c != CHAR_LBRACKET || last) scan_bad = 1'b1;
            if (last) begin
               emit = 1'b1;
               scan_clear();
            end
            return;
         end
      end
      if (!last) begin
         scan_content(c);
         return;
      end
      if (scan_br) begin
         if (c != CHAR_RBRACKET) scan_bad = 1'b1;
      end else begin
         scan_content(c);
      end
      if (scan_phase == PH_ZONE) begin
         if (scan_zpos < (scan_br ? ZPOS_BR_MIN : ZPOS_PLAIN_MIN)) scan_bad = 1'b1;
      end else if (scan_glen == 0 || scan_glen > GROUP_MAX) begin
         scan_bad = 1'b1;
      end
      emit    = 1'b1;
      verdict = !scan_bad && (scan_double ? (scan_colons < COLONS_DOUBLE_LIMIT)
                                          : (scan_colons == COLONS_FULL));
      scan_clear();
   endtask

   task note_mismatch(input string what, input int want, input int got);
      errors++;
      if (errors <= SHOW_LIMIT)
         $display("[%0t] mismatch: %s expected %0d actual %0d", $realtime, what, want, got);
   endtask

   // accepted bytes feed the scanner model; accepted verdicts are checked
   always @(posedge clock) begin
      bit emit;
      bit verdict;
      bit want;
      cycles++;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            scan_byte(req_if.char_byte, req_if.last_byte, req_if.bracketed, emit, verdict);
            if (emit)
               verdicts_due.push_back(row_verdict == NO_VERDICT ? verdict : row_verdict[0]);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (rsp_if.is_valid) seen_valid++;
            else seen_invalid++;
            if (verdicts_due.size() == 0) begin
               note_mismatch("unexpected verdict, none due", NO_VERDICT, rsp_if.is_valid);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_if.is_valid !== want) note_mismatch("is_valid", want, rsp_if.is_valid);
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding", cycles,
                  verdicts_due.size());
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

   // called at a falling edge, returns at the falling edge after the item is taken
   task push_byte(input logic [7:0] c, input bit last, input bit br);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_byte <= c;
      req_if.last_byte <= last;
      req_if.bracketed <= br;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
      calm = (bytes_sent >= 700 && bytes_sent < 1100);
      @(negedge clock);
   endtask

   // bracketed only matters on the first byte, so it is scrambled elsewhere
   task send_string(input bit br, input int verdict);
      row_verdict = verdict;
      for (int i = 0; i < str_bytes.size(); i++)
         push_byte(str_bytes[i], i == str_bytes.size() - 1,
                   i == 0 ? br : 1'($urandom_range(0, 1)));
      strings_sent++;
   endtask

   task add_group();
      int len;
      len = ($urandom_range(0, 29) == 0) ? 5 : $urandom_range(1, 4);
      repeat (len) str_bytes.push_back(HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)]);
   endtask

   task gen_literal();
      int ngrp;
      int dpos;
      int zlen;
      bit use_dbl;
      str_bytes.delete();
      str_br  = $urandom_range(0, 1);
      use_dbl = $urandom_range(0, 1);
      if (use_dbl) ngrp = $urandom_range(0, 7);
      else ngrp = ($urandom_range(0, 3) != 0) ? 8 : $urandom_range(6, 9);
      dpos = use_dbl ? $urandom_range(0, ngrp) : NO_VERDICT;
      if (str_br) str_bytes.push_back(CHAR_LBRACKET);
      for (int g = 0; g < ngrp + int'(use_dbl); g++) begin
         if (g > 0) str_bytes.push_back(CHAR_COLON);
         if (g != dpos) add_group();
         else if ((g == 0 || g == ngrp) && $urandom_range(0, 1))
            str_bytes.push_back(CHAR_COLON);   // leading or trailing double colon
      end
      if ($urandom_range(0, 2) == 0) begin
         str_bytes.push_back(CHAR_PERCENT);
         if (str_br) begin
            str_bytes.push_back(CHAR_TWO);
            str_bytes.push_back(CHAR_FIVE);
         end
         zlen = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 4);
         repeat (zlen) begin
            if ($urandom_range(0, 7) == 0)
               str_bytes.push_back(SPECIAL_CHARS[$urandom_range(0, SPECIAL_CHARS.len() - 1)]);
            else
               str_bytes.push_back(ALNUM_CHARS[$urandom_range(0, ALNUM_CHARS.len() - 1)]);
         end
      end
      if (str_br) str_bytes.push_back(CHAR_RBRACKET);
      if (str_bytes.size() == 0) str_bytes.push_back(HEX_CHARS[$urandom_range(0, 21)]);
   endtask

   task mutate_string();
      int idx;
      idx = $urandom_range(0, str_bytes.size() - 1);
      case ($urandom_range(0, 3))
         0: str_bytes[idx] = 8'($urandom_range(0, 255));
         1: str_bytes[idx] = SPECIAL_CHARS[$urandom_range(0, SPECIAL_CHARS.len() - 1)];
         2: if (str_bytes.size() > 1) str_bytes.delete(idx);
         default: str_bytes.insert(idx, str_bytes[idx]);
      endcase
   endtask

   task gen_noise();
      int len;
      str_bytes.delete();
      str_br = $urandom_range(0, 1);
      len = $urandom_range(1, 8);
      repeat (len) begin
         if ($urandom_range(0, 1))
            str_bytes.push_back(8'($urandom_range(0, 255)));
         else
            str_bytes.push_back(SPECIAL_CHARS[$urandom_range(0, SPECIAL_CHARS.len() - 1)]);
      end
   endtask

   initial begin
      int pick;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.char_byte = '0;
      req_if.last_byte = 1'b0;
      req_if.bracketed = 1'b0;
      rsp_if.ready     = 1'b0;
      scan_clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (lit_cases[r]) begin
         str_bytes.delete();
         for (int i = 0; i < lit_cases[r].text.len(); i++)
            str_bytes.push_back(lit_cases[r].text[i]);
         send_string(lit_cases[r].br, lit_cases[r].verdict);
      end

      // mostly well-formed literals, some damaged, some plain noise
      while (bytes_sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            gen_noise();
         end else begin
            gen_literal();
            if (pick < 32) mutate_string();
         end
         send_string(str_br, NO_VERDICT);
      end
      req_if.valid <= 1'b0;

      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d strings, %0d bytes: brackets, zones, double colons, long groups,",
               strings_sent, bytes_sent);
      $display("saturated colon counts and noise; verdicts seen: %0d valid, %0d invalid",
               seen_valid, seen_invalid);
      if (errors == 0 && verdicts_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d verdicts missing", errors, verdicts_due.size());
         $display("FAIL");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/ipv6lv_pkg.sv
hdl/ipv6lv_if.sv
hdl/ipv6lv_scan.sv
hdl/ipv6_literal_validator_unit.sv
dv/ipv6_literal_validator_unit_tb.sv
